// File: rtl/rarc_pkg.sv
// Shared types and constants for the region access range checker.
// No dependencies.
package rarc_pkg;

  localparam int unsigned MaxRanks = 64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic SPACE_REGION = 1'b0;
  localparam logic SPACE_SPM    = 1'b1;

  localparam logic [1:0] ACC_READ = 2'd0;

  localparam logic [2:0] ROLE_OUTPUT    = 3'd3;
  localparam logic [2:0] ROLE_WORKSPACE = 3'd4;
  localparam logic [2:0] ROLE_STATUS    = 3'd5;

  localparam logic [1:0] CFG_SPM_BASE   = 2'd0;
  localparam logic [1:0] CFG_SPM_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_RANK_COUNT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_RANK  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN   = 3'd2;
  localparam logic [2:0] ST_MISALIGN  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;
  localparam logic [2:0] ST_SPM       = 3'd5;
  localparam logic [2:0] ST_CROSS     = 3'd6;
  localparam logic [2:0] ST_DENIED    = 3'd7;

  typedef struct packed {
    logic        hit;
    logic [63:0] base;
    logic [63:0] rend;
    logic [2:0]  role;
    logic [5:0]  owner;
    logic [7:0]  ordinal;
  } rarc_sel_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  idx;
    logic        valid;
    logic [63:0] base;
    logic [63:0] size;
    logic [5:0]  owner;
    logic [7:0]  ordinal;
    logic [2:0]  role;
  } rarc_wr_t;

  function automatic logic role_writable(input logic [2:0] role);
    role_writable = (role == ROLE_OUTPUT) || (role == ROLE_WORKSPACE) ||
                    (role == ROLE_STATUS);
  endfunction

endpackage

// File: rtl/rarc_table.sv
// Region table storage with its write port and first-match lookup.
// Depends on rarc_pkg.
module rarc_table import rarc_pkg::*; #(
  parameter int unsigned REGION_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rarc_wr_t    wr,
  input  logic [63:0] lookup_addr,
  output rarc_sel_t   sel
);

  localparam int unsigned IW = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;

  logic [REGION_ENTRIES-1:0] usable_r;
  logic [63:0] base_r  [REGION_ENTRIES];
  logic [63:0] rend_r  [REGION_ENTRIES];
  logic [5:0]  owner_r [REGION_ENTRIES];
  logic [7:0]  ord_r   [REGION_ENTRIES];
  logic [2:0]  role_r  [REGION_ENTRIES];

  logic [64:0]   wsum;
  logic [IW-1:0] widx;
  logic          wen;

  assign wsum = {1'b0, wr.base} + {1'b0, wr.size};
  assign widx = wr.idx[IW-1:0];
  assign wen  = wr.we && (int'(wr.idx) < int'(REGION_ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r <= '0;
    end else if (wen) begin
      usable_r[widx] <= wr.valid && !wsum[64];
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      base_r[widx]  <= wr.base;
      rend_r[widx]  <= wsum[63:0];
      owner_r[widx] <= wr.owner;
      ord_r[widx]   <= wr.ordinal;
      role_r[widx]  <= wr.role;
    end
  end

  always_comb begin
    sel = '0;
    for (int i = REGION_ENTRIES - 1; i >= 0; i--) begin
      if (usable_r[i] && (lookup_addr >= base_r[i]) && (lookup_addr < rend_r[i])) begin
        sel.hit     = 1'b1;
        sel.base    = base_r[i];
        sel.rend    = rend_r[i];
        sel.role    = role_r[i];
        sel.owner   = owner_r[i];
        sel.ordinal = ord_r[i];
      end
    end
  end

endmodule

// File: rtl/region_access_range_checker_core.sv
// Throughput: one transaction per cycle; everything holds only while a result waits on out_stall.
// Stage one checks rank, length, alignment and overflow; stage two writes or searches
// the region table; stage three resolves status and offset; stage four is the output.
// Reset clears every region valid bit and sets the configuration registers to defaults.
module region_access_range_checker_core import rarc_pkg::*; #(
  parameter int unsigned REGION_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [3:0]  in_entry_index,
  input  logic        in_entry_valid,
  input  logic [7:0]  in_entry_ordinal,
  input  logic [2:0]  in_entry_role,
  input  logic [5:0]  in_rank,
  input  logic        in_space,
  input  logic [1:0]  in_access,
  input  logic [63:0] in_address,
  input  logic [63:0] in_byte_count,
  input  logic [63:0] in_alignment,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_owner_rank,
  output logic        out_has_ordinal,
  output logic [7:0]  out_slot_ordinal,
  output logic [63:0] out_offset,
  output logic [63:0] out_length
);

  logic [63:0] spm_base_r, spm_limit_r;
  logic [6:0]  rank_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_base_r   <= '0;
      spm_limit_r  <= '0;
      rank_count_r <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPM_BASE:   spm_base_r   <= cfg_data;
        CFG_SPM_LIMIT:  spm_limit_r  <= cfg_data;
        CFG_RANK_COUNT: rank_count_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage one.
  logic        v1_r, op1_r, ev1_r, sp1_r;
  logic [3:0]  idx1_r;
  logic [7:0]  ord1_r;
  logic [2:0]  role1_r;
  logic [5:0]  rank1_r;
  logic [1:0]  acc1_r;
  logic [63:0] addr1_r, cnt1_r, algn1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r   <= in_op;
      idx1_r  <= in_entry_index;
      ev1_r   <= in_entry_valid;
      ord1_r  <= in_entry_ordinal;
      role1_r <= in_entry_role;
      rank1_r <= in_rank;
      sp1_r   <= in_space;
      acc1_r  <= in_access;
      addr1_r <= in_address;
      cnt1_r  <= in_byte_count;
      algn1_r <= in_alignment;
    end
  end

  logic [64:0] sum1;
  logic [63:0] am1;
  logic [2:0]  early1;

  assign sum1 = {1'b0, addr1_r} + {1'b0, cnt1_r};
  assign am1  = algn1_r - 64'd1;

  always_comb begin
    if ((int'(rank1_r) >= int'(rank_count_r)) || (int'(rank1_r) >= int'(MaxRanks))) begin
      early1 = ST_BAD_RANK;
    end else if (cnt1_r == '0) begin
      early1 = ST_UNKNOWN;
    end else if ((algn1_r == '0) || ((algn1_r & am1) != '0) || ((addr1_r & am1) != '0)) begin
      early1 = ST_MISALIGN;
    end else if (sum1[64]) begin
      early1 = ST_OVERFLOW;
    end else begin
      early1 = ST_OK;
    end
  end

  // Stage two.
  logic        v2_r, op2_r, ev2_r, sp2_r;
  logic [3:0]  idx2_r;
  logic [7:0]  ord2_r;
  logic [2:0]  role2_r, early2_r;
  logic [5:0]  rank2_r;
  logic [1:0]  acc2_r;
  logic [63:0] addr2_r, cnt2_r, end2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2_r    <= op1_r;
      idx2_r   <= idx1_r;
      ev2_r    <= ev1_r;
      ord2_r   <= ord1_r;
      role2_r  <= role1_r;
      rank2_r  <= rank1_r;
      sp2_r    <= sp1_r;
      acc2_r   <= acc1_r;
      addr2_r  <= addr1_r;
      cnt2_r   <= cnt1_r;
      end2_r   <= sum1[63:0];
      early2_r <= early1;
    end
  end

  rarc_wr_t  wr;
  rarc_sel_t sel2;

  always_comb begin
    wr.we      = v2_r && adv && (op2_r == OP_WRITE);
    wr.idx     = {4'd0, idx2_r};
    wr.valid   = ev2_r;
    wr.base    = addr2_r;
    wr.size    = cnt2_r;
    wr.owner   = rank2_r;
    wr.ordinal = ord2_r;
    wr.role    = role2_r;
  end

  rarc_table #(.REGION_ENTRIES(REGION_ENTRIES)) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .lookup_addr(addr2_r),
    .sel        (sel2)
  );

  // Stage three.
  logic        v3_r, op3_r, sp3_r, spbad3_r;
  logic [2:0]  early3_r;
  logic [5:0]  rank3_r;
  logic [1:0]  acc3_r;
  logic [63:0] addr3_r, cnt3_r, end3_r, spoff3_r;
  rarc_sel_t   sel3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op3_r    <= op2_r;
      sp3_r    <= sp2_r;
      early3_r <= early2_r;
      rank3_r  <= rank2_r;
      acc3_r   <= acc2_r;
      addr3_r  <= addr2_r;
      cnt3_r   <= cnt2_r;
      end3_r   <= end2_r;
      spbad3_r <= (addr2_r < spm_base_r) || (end2_r > spm_limit_r);
      spoff3_r <= addr2_r - spm_base_r;
      sel3_r   <= sel2;
    end
  end

  logic [2:0]  st_nxt;
  logic [5:0]  own_nxt;
  logic        hord_nxt;
  logic [7:0]  ord_nxt;
  logic [63:0] off_nxt, len_nxt;

  always_comb begin
    st_nxt   = ST_OK;
    own_nxt  = '0;
    hord_nxt = 1'b0;
    ord_nxt  = '0;
    off_nxt  = '0;
    len_nxt  = '0;
    if (op3_r == OP_CHECK) begin
      if (early3_r != ST_OK) begin
        st_nxt = early3_r;
      end else if (sp3_r == SPACE_SPM) begin
        if (spbad3_r) begin
          st_nxt = ST_SPM;
        end else begin
          own_nxt = rank3_r;
          off_nxt = spoff3_r;
          len_nxt = cnt3_r;
        end
      end else if (!sel3_r.hit) begin
        st_nxt = ST_UNKNOWN;
      end else if (end3_r > sel3_r.rend) begin
        st_nxt = ST_CROSS;
      end else if ((acc3_r != ACC_READ) && !role_writable(sel3_r.role)) begin
        st_nxt = ST_DENIED;
      end else begin
        own_nxt  = sel3_r.owner;
        hord_nxt = 1'b1;
        ord_nxt  = sel3_r.ordinal;
        off_nxt  = addr3_r - sel3_r.base;
        len_nxt  = cnt3_r;
      end
    end
  end

  // Output stage.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status       <= st_nxt;
      out_owner_rank   <= own_nxt;
      out_has_ordinal  <= hord_nxt;
      out_slot_ordinal <= ord_nxt;
      out_offset       <= off_nxt;
      out_length       <= len_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: tb/sv/region_access_range_checker_core_tb.sv
// Self-checking testbench for region_access_range_checker_core: queued transactions,
// a predictor of the region table and the access checks, and field-by-field comparison.
// Depends on rarc_pkg and the region_access_range_checker_core RTL.
module region_access_range_checker_core_tb;
  import rarc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic        ev;
    logic [7:0]  ord;
    logic [2:0]  role;
    logic [5:0]  rank;
    logic        space;
    logic [1:0]  acc;
    logic [63:0] addr;
    logic [63:0] cnt;
    logic [63:0] align;
  } access_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  owner;
    logic        has_ord;
    logic [7:0]  ord;
    logic [63:0] offset;
    logic [63:0] length;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_SPM_BASE;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = OP_WRITE;
  logic [3:0] in_entry_index = '0;
  logic in_entry_valid = 1'b0;
  logic [7:0] in_entry_ordinal = '0;
  logic [2:0] in_entry_role = '0;
  logic [5:0] in_rank = '0;
  logic in_space = SPACE_REGION;
  logic [1:0] in_access = ACC_READ;
  logic [63:0] in_address = '0;
  logic [63:0] in_byte_count = '0;
  logic [63:0] in_alignment = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [5:0] out_owner_rank;
  logic out_has_ordinal;
  logic [7:0] out_slot_ordinal;
  logic [63:0] out_offset;
  logic [63:0] out_length;

  region_access_range_checker_core u_top (.*);

  always #5 clk = ~clk;

  // Predictor state.
  logic        tbl_valid [16];
  logic [63:0] tbl_base  [16];
  logic [63:0] tbl_size  [16];
  logic [5:0]  tbl_owner [16];
  logic [7:0]  tbl_ord   [16];
  logic [2:0]  tbl_role  [16];
  logic [63:0] win_base = '0;
  logic [63:0] win_limit = '0;
  logic [6:0]  ranks = 7'd1;

  access_req_t pending_reqs[$];
  verdict_t    expected_verdicts[$];
  access_req_t cur_req;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int checked = 0;
  int status_seen [8];

  function automatic logic role_ok_for_write(logic [2:0] role);
    return role == ROLE_OUTPUT || role == ROLE_WORKSPACE || role == ROLE_STATUS;
  endfunction

  function automatic verdict_t check_access(access_req_t r);
    verdict_t v;
    logic [63:0] last;
    logic [63:0] rend;
    v = '{default: '0};
    v.status = ST_OK;
    if (r.op == OP_WRITE) begin
      tbl_valid[r.idx] = r.ev;
      tbl_base[r.idx] = r.addr;
      tbl_size[r.idx] = r.cnt;
      tbl_owner[r.idx] = r.rank;
      tbl_ord[r.idx] = r.ord;
      tbl_role[r.idx] = r.role;
      return v;
    end
    if ({1'b0, r.rank} >= ranks) begin
      v.status = ST_BAD_RANK;
      return v;
    end
    if (r.cnt == 0) begin
      v.status = ST_UNKNOWN;
      return v;
    end
    if (r.align == 0 || (r.align & (r.align - 1)) != 0 || (r.addr & (r.align - 1)) != 0) begin
      v.status = ST_MISALIGN;
      return v;
    end
    if (r.cnt > ~r.addr) begin
      v.status = ST_OVERFLOW;
      return v;
    end
    last = r.addr + r.cnt;
    if (r.space == SPACE_SPM) begin
      if (r.addr < win_base || last > win_limit) begin
        v.status = ST_SPM;
        return v;
      end
      v.owner = r.rank;
      v.offset = r.addr - win_base;
      v.length = r.cnt;
      return v;
    end
    for (int i = 0; i < 16; i++) begin
      if (!tbl_valid[i] || tbl_size[i] > ~tbl_base[i]) continue;
      rend = tbl_base[i] + tbl_size[i];
      if (r.addr >= tbl_base[i] && r.addr < rend) begin
        if (last > rend) v.status = ST_CROSS;
        else if (r.acc != ACC_READ && !role_ok_for_write(tbl_role[i])) v.status = ST_DENIED;
        else begin
          v.owner = tbl_owner[i];
          v.has_ord = 1'b1;
          v.ord = tbl_ord[i];
          v.offset = r.addr - tbl_base[i];
          v.length = r.cnt;
        end
        return v;
      end
    end
    v.status = ST_UNKNOWN;
    return v;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [5:0] pick_rank();
    int top;
    top = (ranks == 0) ? 0 : ((ranks > 64) ? 63 : ranks - 1);
    if ($urandom_range(99) < 85) return 6'($urandom_range(top, 0));
    return 6'($urandom);
  endfunction

  function automatic access_req_t random_req();
    access_req_t r;
    int kind;
    r.op = OP_CHECK;
    r.idx = 4'($urandom);
    r.ev = $urandom_range(9) != 0;
    r.ord = 8'($urandom);
    r.role = 3'($urandom);
    r.rank = pick_rank();
    r.space = SPACE_REGION;
    r.acc = 2'($urandom);
    r.align = 64'd1 << $urandom_range(6, 0);
    r.cnt = 64'($urandom_range(32'h400, 1));
    kind = $urandom_range(99);
    if (kind < 20) begin
      r.op = OP_WRITE;
      r.rank = 6'($urandom);
      r.addr = 64'($urandom_range(31, 0)) << 12;
      r.cnt = 64'($urandom_range(32'h2000, 1));
      if ($urandom_range(19) == 0) r.cnt = 0;
      if ($urandom_range(19) == 0) begin
        r.addr = ~64'($urandom_range(32'h1000, 0));
        r.cnt = 64'($urandom_range(32'h2000, 1));
      end
    end else if (kind < 65) begin
      r.addr = (64'($urandom_range(31, 0)) << 12) + 64'($urandom_range(32'h2fff, 0));
      r.addr = r.addr & ~(r.align - 1);
    end else if (kind < 85) begin
      r.space = SPACE_SPM;
      r.addr = (win_base + 64'($urandom_range(32'h1100, 0))) & ~(r.align - 1);
    end else begin
      r.op = 1'($urandom);
      r.rank = 6'($urandom);
      r.space = 1'($urandom);
      r.addr = rand64();
      r.cnt = ($urandom_range(3) == 0) ? 64'd0 : rand64();
      r.align = $urandom_range(1) ? rand64() : (64'd1 << $urandom_range(63, 0));
    end
    return r;
  endfunction

  function automatic access_req_t mk(logic op, logic [3:0] idx, logic ev, logic [7:0] ord,
                                     logic [2:0] role, logic [5:0] rank, logic space,
                                     logic [1:0] acc, logic [63:0] addr, logic [63:0] cnt,
                                     logic [63:0] align);
    access_req_t r;
    r = '{op, idx, ev, ord, role, rank, space, acc, addr, cnt, align};
    return r;
  endfunction

  function automatic void post_req(access_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Sender.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_verdicts.insert(expected_verdicts.size(), check_access(cur_req));
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_op <= cur_req.op;
          in_entry_index <= cur_req.idx;
          in_entry_valid <= cur_req.ev;
          in_entry_ordinal <= cur_req.ord;
          in_entry_role <= cur_req.role;
          in_rank <= cur_req.rank;
          in_space <= cur_req.space;
          in_access <= cur_req.acc;
          in_address <= cur_req.addr;
          in_byte_count <= cur_req.cnt;
          in_alignment <= cur_req.align;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result transaction, status %0d", out_status);
        errors++;
      end else begin
        e = expected_verdicts.pop_front();
        checked++;
        status_seen[e.status]++;
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
        if (out_owner_rank !== e.owner) begin
          $error("owner_rank: expected %0d, got %0d", e.owner, out_owner_rank);
          errors++;
        end
        if (out_has_ordinal !== e.has_ord) begin
          $error("has_ordinal: expected %0d, got %0d", e.has_ord, out_has_ordinal);
          errors++;
        end
        if (out_slot_ordinal !== e.ord) begin
          $error("slot_ordinal: expected %0d, got %0d", e.ord, out_slot_ordinal);
          errors++;
        end
        if (out_offset !== e.offset) begin
          $error("offset: expected %h, got %h", e.offset, out_offset);
          errors++;
        end
        if (out_length !== e.length) begin
          $error("length: expected %h, got %h", e.length, out_length);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_SPM_BASE) win_base = val;
    else if (idx == CFG_SPM_LIMIT) win_limit = val;
    else ranks = val[6:0];
  endtask

  task automatic configure(logic [63:0] b, logic [63:0] l, logic [63:0] rc);
    write_reg(CFG_SPM_BASE, b);
    write_reg(CFG_SPM_LIMIT, l);
    write_reg(CFG_RANK_COUNT, rc);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_verdicts.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_phase(int n, int s_idle, int r_stall, logic hold);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    if (hold) hold_req <= 1'b1;
    for (int i = 0; i < n; i++) post_req(random_req());
    if (hold) begin
      @(posedge clk);
      @(posedge clk);
      hold_req <= 1'b0;
    end
    drain();
  endtask

  initial begin
    logic [63:0] top;
    top = '1;
    for (int i = 0; i < 16; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_base[i] = '0;
      tbl_size[i] = '0;
      tbl_owner[i] = '0;
      tbl_ord[i] = '0;
      tbl_role[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    configure(64'h10000, 64'h20000, 64);
    post_req(mk(OP_WRITE, 0, 1, 5, 0, 3, 0, 0, 64'h1000, 64'h1000, 0));
    post_req(mk(OP_WRITE, 1, 1, 9, 4, 7, 0, 0, 64'h1800, 64'h1000, 0));
    post_req(mk(OP_WRITE, 15, 1, 255, 5, 63, 0, 0, top - 15, 64'h20, 0));
    post_req(mk(OP_WRITE, 2, 1, 1, 4, 1, 0, 0, 64'h4000, 0, 0));
    post_req(mk(OP_WRITE, 3, 1, 2, 6, 2, 0, 0, 64'h5000, 64'h100, 0));
    post_req(mk(OP_WRITE, 4, 0, 3, 3, 4, 0, 0, 64'h6000, 64'h100, 0));
    post_req(mk(OP_WRITE, 5, 1, 4, 7, 5, 0, 0, 64'h7000, 64'h100, 0));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 63, 0, 0, 64'h1800, 64'h10, 8));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 64'h1000, 0, 1));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 64'h1000, 4, 0));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 64'h1000, 4, 3));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 64'h1002, 4, 4));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, top, 2, 1));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, top - 7, 4, 1));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 9, 1, 1, 64'h10040, 64'h40, 64));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 9, 1, 0, 64'h1ffff, 2, 1));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 1, 0, 1, 64'h1100, 64'h10, 16));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 1, 0, 0, 64'h1100, 64'h10, 16));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 1, 0, 2, 64'h2000, 64'h900, 1));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 1, 0, 3, 64'h2000, 64'h10, 1));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 1, 0, 0, 64'h4000, 1, 1));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 1, 0, 1, 64'h5000, 1, 1));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 1, 0, 0, 64'h7000, 1, 1));
    post_req(mk(OP_CHECK, 0, 0, 0, 0, 1, 0, 0, 64'h6000, 1, 1));
    drain();
    configure(64'h10000, 64'h20000, 127);
    random_phase(480, 0, 0, 1'b0);
    configure(64'h0, top, 1);
    random_phase(480, 83, 0, 1'b0);
    configure(64'h10000, 64'h10000, 0);
    random_phase(480, 0, 83, 1'b1);
    configure(top - 64'hfff, top, 40);
    random_phase(480, 15, 15, 1'b0);
    repeat (20) @(posedge clk);
    $display("Checked %0d result transactions over five configurations and idling patterns.",
             checked);
    $display("Status counts ok..denied: %0d %0d %0d %0d %0d %0d %0d %0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3], status_seen[4], status_seen[5],
             status_seen[6], status_seen[7]);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("region_access_range_checker_core_tb: done, clean");
    end else begin
      $display("region_access_range_checker_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("region_access_range_checker_core_tb: done, errors");
    $finish;
  end

endmodule
